/* rtl/chinese_numeral_to_integer_macros.svh */
// Assertion macros shared by the numeral reader RTL.
// Each macro expects a clk and an active-high rst in the enclosing module.
`ifndef CHINESE_NUMERAL_TO_INTEGER_MACROS_SVH
`define CHINESE_NUMERAL_TO_INTEGER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define CNTI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define CNTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cnti_pkg.sv */
// Package for the Chinese numeral reader: types, code points, limits.
// No dependencies; imported by every module of the block.
`default_nettype none

package cnti_pkg;

  localparam int CP_W     = 21;
  localparam int VALUE_W  = 44;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 4;

  // Largest value the reader reports
  localparam longint unsigned LIMIT_NUM = 64'd9999999999999;
  localparam logic [VALUE_W-1:0] VALUE_LIMIT = VALUE_W'(LIMIT_NUM);
  // Largest section base that may still be scaled by a large unit
  localparam logic [VALUE_W-1:0] TEN_K_BASE_MAX     = VALUE_W'(LIMIT_NUM / 10000);
  localparam logic [VALUE_W-1:0] HUNDRED_M_BASE_MAX = VALUE_W'(LIMIT_NUM / 100000000);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Digit code points
  localparam logic [CP_W-1:0] CP_LING      = 21'h096F6;
  localparam logic [CP_W-1:0] CP_CIRCLE    = 21'h03007;
  localparam logic [CP_W-1:0] CP_YI        = 21'h04E00;
  localparam logic [CP_W-1:0] CP_ER        = 21'h04E8C;
  localparam logic [CP_W-1:0] CP_LIANG     = 21'h04E24;
  localparam logic [CP_W-1:0] CP_SAN       = 21'h04E09;
  localparam logic [CP_W-1:0] CP_SI        = 21'h056DB;
  localparam logic [CP_W-1:0] CP_WU        = 21'h04E94;
  localparam logic [CP_W-1:0] CP_LIU       = 21'h0516D;
  localparam logic [CP_W-1:0] CP_QI        = 21'h04E03;
  localparam logic [CP_W-1:0] CP_BA        = 21'h0516B;
  localparam logic [CP_W-1:0] CP_JIU       = 21'h04E5D;
  // Unit code points
  localparam logic [CP_W-1:0] CP_SHI       = 21'h05341;
  localparam logic [CP_W-1:0] CP_BAI       = 21'h0767E;
  localparam logic [CP_W-1:0] CP_QIAN      = 21'h05343;
  localparam logic [CP_W-1:0] CP_WAN       = 21'h04E07;
  localparam logic [CP_W-1:0] CP_YI_UNIT   = 21'h04EBF;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_UNIT,
    KIND_BAD
  } kind_t;

  typedef enum logic [2:0] {
    UNIT_TEN,
    UNIT_HUNDRED,
    UNIT_THOUSAND,
    UNIT_TEN_K,
    UNIT_HUNDRED_M
  } unit_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // One classified character
  typedef struct packed {
    kind_t              kind;
    logic [DIGIT_W-1:0] digit;
    unit_t              unit;
    logic               last;
  } class_item_t;

  // Complete parse state of one numeral
  typedef struct packed {
    logic [VALUE_W-1:0] total_acc;
    logic [VALUE_W-1:0] section_acc;
    logic [DIGIT_W-1:0] pending_digit;
    logic [VALUE_W-1:0] concat_acc;
    logic               only_digits_seen;
    logic               bad_char_seen;
    logic               unit_overflow_seen;
    logic               concat_overflow_seen;
  } snapshot_t;

endpackage

`default_nettype wire

/* rtl/cnti_front.sv */
// Front end: classifies one code point as digit, unit or bad character.
// Depends on cnti_pkg.
`default_nettype none

module cnti_front import cnti_pkg::*; (
  input  logic [CP_W-1:0] code_point,
  input  logic            last,
  output class_item_t     item
);

  // Code point decoder
  always_comb begin
    item.kind  = KIND_DIGIT;
    item.digit = '0;
    item.unit  = UNIT_TEN;
    item.last  = last;
    unique case (code_point)
      CP_LING, CP_CIRCLE: item.digit = 4'd0;
      CP_YI:              item.digit = 4'd1;
      CP_ER, CP_LIANG:    item.digit = 4'd2;
      CP_SAN:             item.digit = 4'd3;
      CP_SI:              item.digit = 4'd4;
      CP_WU:              item.digit = 4'd5;
      CP_LIU:             item.digit = 4'd6;
      CP_QI:              item.digit = 4'd7;
      CP_BA:              item.digit = 4'd8;
      CP_JIU:             item.digit = 4'd9;
      CP_SHI: begin
        item.kind = KIND_UNIT;
        item.unit = UNIT_TEN;
      end
      CP_BAI: begin
        item.kind = KIND_UNIT;
        item.unit = UNIT_HUNDRED;
      end
      CP_QIAN: begin
        item.kind = KIND_UNIT;
        item.unit = UNIT_THOUSAND;
      end
      CP_WAN: begin
        item.kind = KIND_UNIT;
        item.unit = UNIT_TEN_K;
      end
      CP_YI_UNIT: begin
        item.kind = KIND_UNIT;
        item.unit = UNIT_HUNDRED_M;
      end
      default: item.kind = KIND_BAD;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/cnti_queue.sv */
// Small FIFO of classified characters between front and back end.
// Depends on cnti_pkg and the assertion macro header.
`default_nettype none

`include "chinese_numeral_to_integer_macros.svh"

module cnti_queue import cnti_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  class_item_t push_item,
  output logic        not_full,
  input  logic        pop,
  output logic        head_valid,
  output class_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  class_item_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full   = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CNTI_ASSERT(a_queue_no_overrun, count <= CNT_FULL, "queue fill level beyond depth")
  `CNTI_ASSERT(a_queue_no_underrun, !pop || count != '0, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/cnti_back.sv */
// Back end: applies classified characters to the concatenation and unit
// readings, one per cycle unless a last one waits for the finish stage,
// which takes the final state. Depends on cnti_pkg and the macro header.
`default_nettype none

`include "chinese_numeral_to_integer_macros.svh"

module cnti_back import cnti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  class_item_t head,
  output logic        head_take,
  input  logic        fin_free,
  output logic        fin_load,
  output snapshot_t   fin_data
);

  localparam int TEN_K_BASE_W     = $clog2(TEN_K_BASE_MAX + 1);
  localparam int HUNDRED_M_BASE_W = $clog2(HUNDRED_M_BASE_MAX + 1);
  localparam int SMALL_W          = 14;  // nine times one thousand

  // Parse state at the start of a numeral
  localparam snapshot_t ST_RESET = '{
    total_acc:            '0,
    section_acc:          '0,
    pending_digit:        '0,
    concat_acc:           '0,
    only_digits_seen:     1'b1,
    bad_char_seen:        1'b0,
    unit_overflow_seen:   1'b0,
    concat_overflow_seen: 1'b0
  };

  snapshot_t st;
  snapshot_t st_next;
  snapshot_t upd;

  logic [VALUE_W+3:0]  concat_wide;
  logic [DIGIT_W-1:0]  num;
  logic [9:0]          small_unit;
  logic [SMALL_W-1:0]  small_add;
  logic [VALUE_W:0]    small_sum;
  logic [VALUE_W:0]    base;
  logic [VALUE_W-1:0]  base_max;
  logic [VALUE_W-1:0]  sec;
  logic [VALUE_W:0]    big_sum;
  logic                big_unit;

  // A last character only moves on when the finish stage has room
  assign head_take = head_valid && (!head.last || fin_free);

  // Unit arithmetic candidates
  always_comb begin
    concat_wide = (VALUE_W+4)'(st.concat_acc) * (VALUE_W+4)'(10)
                  + (VALUE_W+4)'(head.digit);
    num = (head.unit == UNIT_TEN && st.pending_digit == '0) ? DIGIT_W'(1)
                                                            : st.pending_digit;
    case (head.unit)
      UNIT_TEN:      small_unit = 10'd10;
      UNIT_HUNDRED:  small_unit = 10'd100;
      UNIT_THOUSAND: small_unit = 10'd1000;
      default:       small_unit = 10'd0;
    endcase
    small_add = SMALL_W'(num) * SMALL_W'(small_unit);
    small_sum = (VALUE_W+1)'(st.section_acc) + (VALUE_W+1)'(small_add);

    big_unit = (head.unit == UNIT_TEN_K) || (head.unit == UNIT_HUNDRED_M);
    base     = (VALUE_W+1)'(st.section_acc) + (VALUE_W+1)'(st.pending_digit);
    base_max = (head.unit == UNIT_TEN_K) ? TEN_K_BASE_MAX : HUNDRED_M_BASE_MAX;
    if (head.unit == UNIT_TEN_K) begin
      sec = VALUE_W'(base[TEN_K_BASE_W-1:0]) * VALUE_W'(10000);
    end else begin
      sec = VALUE_W'(base[HUNDRED_M_BASE_W-1:0]) * VALUE_W'(100000000);
    end
    big_sum = (VALUE_W+1)'(st.total_acc) + (VALUE_W+1)'(sec);
  end

  // State update for the character at the head of the queue
  always_comb begin
    upd = st;
    case (head.kind)
      KIND_DIGIT: begin
        if (!st.concat_overflow_seen) begin
          if (concat_wide > (VALUE_W+4)'(VALUE_LIMIT)) begin
            upd.concat_overflow_seen = 1'b1;
          end else begin
            upd.concat_acc = concat_wide[VALUE_W-1:0];
          end
        end
        if (!st.unit_overflow_seen) begin
          upd.pending_digit = head.digit;
        end
      end
      KIND_UNIT: begin
        upd.only_digits_seen = 1'b0;
        if (!st.unit_overflow_seen && !st.bad_char_seen) begin
          if (!big_unit) begin
            if (small_sum > (VALUE_W+1)'(VALUE_LIMIT)) begin
              upd.unit_overflow_seen = 1'b1;
            end else begin
              upd.section_acc   = small_sum[VALUE_W-1:0];
              upd.pending_digit = '0;
            end
          end else if (base > (VALUE_W+1)'(base_max)) begin
            upd.unit_overflow_seen = 1'b1;
          end else if (big_sum > (VALUE_W+1)'(VALUE_LIMIT)) begin
            upd.unit_overflow_seen = 1'b1;
          end else begin
            upd.total_acc     = big_sum[VALUE_W-1:0];
            upd.section_acc   = '0;
            upd.pending_digit = '0;
          end
        end
      end
      default: begin
        upd.only_digits_seen = 1'b0;
        upd.bad_char_seen    = 1'b1;
      end
    endcase
  end

  // Next state and hand-off to the finish stage
  always_comb begin
    st_next  = st;
    fin_load = 1'b0;
    fin_data = upd;
    if (head_take) begin
      if (head.last) begin
        fin_load = 1'b1;
        st_next  = ST_RESET;
      end else begin
        st_next = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else begin
      st <= st_next;
    end
  end

  `CNTI_ASSERT_NEXT(a_back_clear_after_last, head_take && head.last,
    st.total_acc == '0 && st.section_acc == '0 && st.concat_acc == '0
      && st.only_digits_seen && !st.bad_char_seen,
    "parse state not cleared after last character")
  `CNTI_ASSERT(a_back_acc_in_range,
    st.total_acc <= VALUE_LIMIT && st.section_acc <= VALUE_LIMIT
      && st.concat_acc <= VALUE_LIMIT,
    "accumulator beyond value limit")

endmodule

`default_nettype wire

/* rtl/cnti_finish.sv */
// Finish stage: turns a final parse state into value and status and holds
// the result in the output register until the receiver takes it.
// Depends on cnti_pkg and the assertion macro header.
`default_nettype none

`include "chinese_numeral_to_integer_macros.svh"

module cnti_finish import cnti_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                fin_load,
  input  snapshot_t           fin_data,
  output logic                fin_free,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [VALUE_W-1:0]  value,
  output logic [STATUS_W-1:0] status
);

  snapshot_t           fin;
  logic                fin_valid;
  logic                out_load;
  logic [VALUE_W+1:0]  sum;
  logic [VALUE_W-1:0]  value_next;
  status_t             status_next;

  assign out_load = fin_valid && (!result_valid || result_ready);
  assign fin_free = !fin_valid || out_load;

  // Pick the reading and check the limit
  always_comb begin
    sum = (VALUE_W+2)'(fin.total_acc) + (VALUE_W+2)'(fin.section_acc)
          + (VALUE_W+2)'(fin.pending_digit);
    value_next  = '0;
    status_next = STATUS_OK;
    if (fin.bad_char_seen) begin
      status_next = STATUS_BAD_CHAR;
    end else if (fin.only_digits_seen) begin
      if (fin.concat_overflow_seen) begin
        status_next = STATUS_OVERFLOW;
      end else begin
        value_next = fin.concat_acc;
      end
    end else if (fin.unit_overflow_seen) begin
      status_next = STATUS_OVERFLOW;
    end else if (sum > (VALUE_W+2)'(VALUE_LIMIT)) begin
      status_next = STATUS_OVERFLOW;
    end else begin
      value_next = sum[VALUE_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin <= fin_data;
    end
    if (out_load) begin
      value  <= value_next;
      status <= status_next;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (fin_load) begin
        fin_valid <= 1'b1;
      end else if (out_load) begin
        fin_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `CNTI_ASSERT(a_fin_zero_on_error, !result_valid || status == STATUS_OK || value == '0,
    "nonzero value with error status")
  `CNTI_ASSERT(a_fin_value_in_range, !result_valid || value <= VALUE_LIMIT,
    "result value beyond limit")
  `CNTI_ASSERT(a_fin_no_overwrite, !fin_load || fin_free, "finish stage overwritten")

endmodule

`default_nettype wire

/* rtl/chinese_numeral_to_integer.sv */
// Chinese numeral reader: one code point per char transfer, with last
// marking the end of a numeral. Exactly one result transfer per numeral,
// carrying value and status (0 ok, 1 bad character, 2 beyond limit).
// Both channels are valid/ready; a transfer happens when both are high.
// Throughput: one character per cycle while nothing stalls, set by the
// combinational update of the back end (one constant multiply, add and
// limit compare per reading). The last character passes the queue, then
// the finish and output registers before result_valid rises.
// The classified-character queue holds QUEUE_DEPTH entries; char_ready
// drops only when it is full. A stalled receiver holds the result in the
// output register; a second finished numeral waits in the finish stage,
// and characters keep flowing until the back end meets the next last
// character with nowhere to put it.
// Reset empties the queue, clears the parse state and drops result_valid.
// Depends on cnti_pkg, cnti_front, cnti_queue, cnti_back, cnti_finish.
`default_nettype none

module chinese_numeral_to_integer import cnti_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  logic [CP_W-1:0]     code_point,
  input  logic                last,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [VALUE_W-1:0]  value,
  output logic [STATUS_W-1:0] status
);

  class_item_t item;
  class_item_t head;
  logic        head_valid;
  logic        head_take;
  logic        fin_free;
  logic        fin_load;
  snapshot_t   fin_data;

  cnti_front u_front (
    .code_point (code_point),
    .last       (last),
    .item       (item)
  );

  cnti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (char_valid && char_ready),
    .push_item  (item),
    .not_full   (char_ready),
    .pop        (head_take),
    .head_valid (head_valid),
    .head       (head)
  );

  cnti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take),
    .fin_free   (fin_free),
    .fin_load   (fin_load),
    .fin_data   (fin_data)
  );

  cnti_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .fin_load     (fin_load),
    .fin_data     (fin_data),
    .fin_free     (fin_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value        (value),
    .status       (status)
  );

endmodule

`default_nettype wire
